FILE: sv/chbd_pkg.sv
package chbd_pkg;

    // Width of the chunk size accumulator / payload down-counter
    localparam int SIZE_BITS = 64;

    localparam int BYTE_W = 8;
    localparam int LINE_W = 16;
    localparam int ERR_W  = 2;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MAX_LINE_LEN = REG_IDX_W'(0);
    localparam logic [LINE_W-1:0]    MAX_LINE_LEN_RST = LINE_W'(4096);

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CRLF = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LINE = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVF  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_payload;
        logic              msg_end;
        logic [ERR_W-1:0]  error_code;
    } chbd_result_t;

endpackage

FILE: sv/http_chunked_body_decoder_core.sv
// HTTP chunked body decoder core.
//
// Input channel (s_valid/s_ready/s_data_byte): raw body bytes, one item per
// byte. Size lines, their CR LF and the CR LF after each chunk are consumed;
// only payload bytes, message end and errors produce a result item.
// Result channel (m_valid/m_ready/m_*): one item per payload byte (is_payload),
// one at the end of the terminating zero chunk (msg_end), and one for the byte
// that raises an error (error_code). After an error every byte is swallowed
// until reset.
// m_valid and m_* are driven from the output register, refilled from the skid slot.
// Throughput: one byte per cycle while s_ready is high; the per-byte state update
// (size accumulate, payload down-count, line length compare) is combinational.
// When the receiver stalls, one more item is held in a skid slot and s_ready
// then drops until the output register drains.
// Reset (aresetn low, synchronous): parser returns to the size line phase,
// errors clear, output and skid slots empty, max_line_len returns to 4096.
// APB register 0 (byte address 0): max_line_len[15:0]; write only while idle.
module http_chunked_body_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [chbd_pkg::BYTE_W-1:0]       s_data_byte,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [chbd_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_is_payload,
    output logic                              m_msg_end,
    output logic [chbd_pkg::ERR_W-1:0]        m_error_code,
    // APB register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [chbd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [chbd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import chbd_pkg::*;

    logic [LINE_W-1:0]    max_line_len_reg;
    logic                 reg_sel;
    logic                 in_accept;
    logic                 res_valid;
    chbd_result_t         res;
    chbd_result_t         m_data;

    // ---- register port: zero wait states ----
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_MAX_LINE_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_line_len_reg <= MAX_LINE_LEN_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            max_line_len_reg <= pwdata[LINE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = {{(APB_DATA_W-LINE_W){1'b0}}, max_line_len_reg};
        end
    end

    // ---- datapath ----
    assign in_accept = s_valid && s_ready;

    chbd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .data_byte    (s_data_byte),
        .max_line_len (max_line_len_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Output register plus skid slot: keeps input flowing while m_ready is low until the skid slot fills
    chbd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept && res_valid),
        .push_data (res),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_out_byte   = m_data.out_byte;
    assign m_is_payload = m_data.is_payload;
    assign m_msg_end    = m_data.msg_end;
    assign m_error_code = m_data.error_code;

endmodule

FILE: sv/chbd_parser.sv
module chbd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_accept,
    input  logic [chbd_pkg::BYTE_W-1:0]   data_byte,
    input  logic [chbd_pkg::LINE_W-1:0]   max_line_len,
    output logic                          res_valid,
    output chbd_pkg::chbd_result_t        res
);
    import chbd_pkg::*;

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_LINE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TAIL = 3'd2;

    localparam logic [BYTE_W-1:0] ASCII_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] ASCII_LF = 8'h0A;

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [SIZE_BITS-1:0] chunk_remaining_reg, chunk_remaining_next;
    logic [LINE_W-1:0]    line_count_reg, line_count_next;
    logic                 last_chunk_reg, last_chunk_next;
    logic                 saw_cr_reg, saw_cr_next;
    logic                 digits_done_reg, digits_done_next;
    logic [ERR_W-1:0]     sticky_error_reg, sticky_error_next;

    logic                 hex_valid;
    logic [3:0]           hex_value;
    logic [LINE_W:0]      line_cnt_inc;

    // Hex digit decode
    always_comb begin
        hex_valid = 1'b1;
        hex_value = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
            hex_value = data_byte[3:0];
        end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                     (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
            hex_value = data_byte[3:0] + 4'd9;
        end else begin
            hex_valid = 1'b0;
        end
    end

    assign line_cnt_inc = {1'b0, line_count_reg} + (LINE_W+1)'(1);

    always_comb begin
        phase_next           = phase_reg;
        chunk_remaining_next = chunk_remaining_reg;
        line_count_next      = line_count_reg;
        last_chunk_next      = last_chunk_reg;
        saw_cr_next          = saw_cr_reg;
        digits_done_next     = digits_done_reg;
        sticky_error_next    = sticky_error_reg;
        res_valid            = 1'b0;
        res                  = '0;

        if (in_accept && sticky_error_reg == ERR_NONE) begin
            unique case (phase_reg)
                PH_DATA: begin
                    chunk_remaining_next = chunk_remaining_reg - SIZE_BITS'(1);
                    if (chunk_remaining_reg == SIZE_BITS'(1)) begin
                        phase_next  = PH_TAIL;
                        saw_cr_next = 1'b0;
                    end
                    res_valid      = 1'b1;
                    res.out_byte   = data_byte;
                    res.is_payload = 1'b1;
                end
                PH_TAIL: begin
                    if (!saw_cr_reg) begin
                        if (data_byte != ASCII_CR) begin
                            sticky_error_next = ERR_CRLF;
                            res_valid         = 1'b1;
                            res.error_code    = ERR_CRLF;
                        end else begin
                            saw_cr_next = 1'b1;
                        end
                    end else if (data_byte != ASCII_LF) begin
                        sticky_error_next = ERR_CRLF;
                        res_valid         = 1'b1;
                        res.error_code    = ERR_CRLF;
                    end else begin
                        saw_cr_next          = 1'b0;
                        phase_next           = PH_LINE;
                        chunk_remaining_next = '0;
                        line_count_next      = '0;
                        digits_done_next     = 1'b0;
                        if (last_chunk_reg) begin
                            last_chunk_next = 1'b0;
                            res_valid       = 1'b1;
                            res.msg_end     = 1'b1;
                        end
                    end
                end
                default: begin
                    // size line (unused codes land here too)
                    if (line_cnt_inc > {1'b0, max_line_len}) begin
                        sticky_error_next = ERR_LINE;
                        res_valid         = 1'b1;
                        res.error_code    = ERR_LINE;
                    end else begin
                        line_count_next = line_cnt_inc[LINE_W-1:0];
                        if (saw_cr_reg && data_byte == ASCII_LF) begin
                            saw_cr_next      = 1'b0;
                            line_count_next  = '0;
                            digits_done_next = 1'b0;
                            if (chunk_remaining_reg == '0) begin
                                last_chunk_next = 1'b1;
                                phase_next      = PH_TAIL;
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end else begin
                            saw_cr_next = (data_byte == ASCII_CR);
                            if (!digits_done_reg) begin
                                if (!hex_valid) begin
                                    digits_done_next = 1'b1;
                                end else if (chunk_remaining_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                                    sticky_error_next = ERR_OVF;
                                    res_valid         = 1'b1;
                                    res.error_code    = ERR_OVF;
                                end else begin
                                    chunk_remaining_next =
                                        {chunk_remaining_reg[SIZE_BITS-5:0], hex_value};
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_LINE;
            chunk_remaining_reg <= '0;
            line_count_reg      <= '0;
            last_chunk_reg      <= 1'b0;
            saw_cr_reg          <= 1'b0;
            digits_done_reg     <= 1'b0;
            sticky_error_reg    <= ERR_NONE;
        end else begin
            phase_reg           <= phase_next;
            chunk_remaining_reg <= chunk_remaining_next;
            line_count_reg      <= line_count_next;
            last_chunk_reg      <= last_chunk_next;
            saw_cr_reg          <= saw_cr_next;
            digits_done_reg     <= digits_done_next;
            sticky_error_reg    <= sticky_error_next;
        end
    end

endmodule

FILE: sv/chbd_out_buf.sv
module chbd_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  chbd_pkg::chbd_result_t push_data,
    output logic                   in_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output chbd_pkg::chbd_result_t m_data
);
    import chbd_pkg::*;

    logic         out_valid_reg, out_valid_next;
    chbd_result_t out_reg, out_next;
    logic         skid_valid_reg, skid_valid_next;
    chbd_result_t skid_reg, skid_next;

    // skid slot catches the one item accepted while the output is stalled
    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: sv/chbd_checker.sv
module chbd_port_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [chbd_pkg::BYTE_W-1:0] m_out_byte,
    input logic                        m_is_payload,
    input logic                        m_msg_end,
    input logic [chbd_pkg::ERR_W-1:0]  m_error_code
);
    import chbd_pkg::*;

    // Output is empty and input open right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("output not empty after reset");

    // Input only backs up when the output register is occupied
    a_ready_backs_up: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty output");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_byte) &&
            $stable(m_is_payload) && $stable(m_msg_end) && $stable(m_error_code)))
        else $error("stalled result changed");

    // A payload item carries no end or error marking
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_payload) |-> (m_error_code == ERR_NONE && !m_msg_end))
        else $error("payload item with end or error flag");

    // Non-payload items carry a zero byte and exactly one marking
    a_marker_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_payload) |->
            (m_out_byte == '0 && (m_msg_end != (m_error_code != ERR_NONE))))
        else $error("malformed marker item");

endmodule

bind http_chunked_body_decoder_core chbd_port_checker u_chbd_checker (.*);

FILE: test/chbd_checker.sv
module chbd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [chbd_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [chbd_pkg::BYTE_W-1:0]     m_out_byte,
    input  logic                            m_is_payload,
    input  logic                            m_msg_end,
    input  logic [chbd_pkg::ERR_W-1:0]      m_error_code,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [chbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [chbd_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [chbd_pkg::APB_DATA_W-1:0] prdata,
    input  logic                            pready,
    output int                              results_owed,
    output int                              mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import chbd_pkg::*;

    localparam logic [BYTE_W-1:0] CHR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_SIZE_LINE = 3'd0,
        PH_PAYLOAD   = 3'd1,
        PH_CHUNK_END = 3'd2
    } parse_phase_e;

    // shadow of the decoder
    logic [LINE_W-1:0]    line_limit  = MAX_LINE_LEN_RST;
    parse_phase_e         phase       = PH_SIZE_LINE;
    logic [SIZE_BITS-1:0] chunk_left  = '0;
    logic [LINE_W-1:0]    line_bytes  = '0;
    logic                 final_chunk = 1'b0;
    logic                 cr_seen     = 1'b0;
    logic                 ext_started = 1'b0;
    logic [ERR_W-1:0]     held_err    = ERR_NONE;

    chbd_result_t owed_results[$];
    int           owed_count = 0;
    int           fail_total = 0;

    assign results_owed = owed_count;
    assign mismatches   = fail_total;

    function automatic bit flag_error(input logic [ERR_W-1:0] code, output chbd_result_t r);
        held_err     = code;
        r            = '0;
        r.error_code = code;
        return 1'b1;
    endfunction

    // Returns 1 when the byte produces a result item.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output chbd_result_t r);
        logic [LINE_W:0] cnt;
        logic [4:0]      nib;
        r = '0;
        if (held_err != ERR_NONE) return 1'b0;
        case (phase)
            PH_PAYLOAD: begin
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0) begin
                    phase   = PH_CHUNK_END;
                    cr_seen = 1'b0;
                end
                r.out_byte   = b;
                r.is_payload = 1'b1;
                return 1'b1;
            end
            PH_CHUNK_END: begin
                if (!cr_seen) begin
                    if (b != CHR_CR) return flag_error(ERR_CRLF, r);
                    cr_seen = 1'b1;
                    return 1'b0;
                end
                if (b != CHR_LF) return flag_error(ERR_CRLF, r);
                cr_seen     = 1'b0;
                phase       = PH_SIZE_LINE;
                chunk_left  = '0;
                line_bytes  = '0;
                ext_started = 1'b0;
                if (final_chunk) begin
                    final_chunk = 1'b0;
                    r.msg_end   = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                // length check comes first, so even the closing LF can trip it
                cnt = {1'b0, line_bytes} + 1'b1;
                if (cnt > {1'b0, line_limit}) return flag_error(ERR_LINE, r);
                line_bytes = cnt[LINE_W-1:0];
                if (cr_seen && b == CHR_LF) begin
                    cr_seen     = 1'b0;
                    line_bytes  = '0;
                    ext_started = 1'b0;
                    if (chunk_left == '0) begin
                        final_chunk = 1'b1;
                        phase       = PH_CHUNK_END;
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                    return 1'b0;
                end
                cr_seen = (b == CHR_CR);
                if (!ext_started) begin
                    if (b >= "0" && b <= "9")
                        nib = {1'b0, b[3:0]};
                    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
                        nib = {1'b0, b[3:0] + 4'd9};
                    else
                        nib = 5'h10;
                    if (nib[4]) begin
                        ext_started = 1'b1;
                    end else begin
                        if (chunk_left[SIZE_BITS-1 -: 4] != 4'h0)
                            return flag_error(ERR_OVF, r);
                        chunk_left = {chunk_left[SIZE_BITS-5:0], nib[3:0]};
                    end
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin : watch
        chbd_result_t predicted;
        if (!aresetn) begin
            line_limit  = MAX_LINE_LEN_RST;
            phase       = PH_SIZE_LINE;
            chunk_left  = '0;
            line_bytes  = '0;
            final_chunk = 1'b0;
            cr_seen     = 1'b0;
            ext_started = 1'b0;
            held_err    = ERR_NONE;
            owed_results.delete();
        end else begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_MAX_LINE_LEN) begin
                if (pwrite)
                    line_limit = pwdata[LINE_W-1:0];
                else if (prdata !== APB_DATA_W'(line_limit)) begin
                    $display("%0t ns: max_line_len readback mismatch, expected %0h, actual %0h",
                             $time, line_limit, prdata);
                    fail_total++;
                end
            end
            if (s_valid && s_ready) begin
                if (decode_byte(s_data_byte, predicted)) owed_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t ns: unexpected item, expected none, actual %0h/%0b/%0b/%0h",
                             $time, m_out_byte, m_is_payload, m_msg_end, m_error_code);
                    fail_total++;
                end else begin
                    predicted = owed_results.pop_front();
                    check_field("out_byte",   predicted.out_byte,   m_out_byte);
                    check_field("is_payload", predicted.is_payload, m_is_payload);
                    check_field("msg_end",    predicted.msg_end,    m_msg_end);
                    check_field("error_code", predicted.error_code, m_error_code);
                end
            end
        end
        owed_count = owed_results.size();
    end

endmodule

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import chbd_pkg::*;

    localparam logic [BYTE_W-1:0] CHR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_LF = 8'h0A;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_byte = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [BYTE_W-1:0]     m_out_byte;
    logic                  m_is_payload;
    logic                  m_msg_end;
    logic [ERR_W-1:0]      m_error_code;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int results_owed;
    int mismatches;

    // bytes waiting to go out, current line limit, no-idle run lengths
    logic [BYTE_W-1:0] body_bytes[$];
    logic [LINE_W-1:0] cur_limit;
    int                tx_quiet = 0;
    int                rx_quiet = 0;

    always #6 aclk = ~aclk;

    http_chunked_body_decoder_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_payload (m_is_payload),
        .m_msg_end    (m_msg_end),
        .m_error_code (m_error_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    chbd_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_payload (m_is_payload),
        .m_msg_end    (m_msg_end),
        .m_error_code (m_error_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .results_owed (results_owed),
        .mismatches   (mismatches)
    );

    // Idle cycles before the next item: mostly short random gaps, now and
    // then a run of back-to-back items.
    function automatic int pick_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            quiet = $urandom_range(8, 64);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    // hex digit in random letter case
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // first byte of an extension: anything that ends the size digits
    function automatic logic [BYTE_W-1:0] non_hex_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 1) == 0) return ";";
        do b = 8'($urandom_range(0, 255));
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
        return b;
    endfunction

    // extension filler; lone CRs allowed, but never CR LF (that ends the line)
    function automatic logic [BYTE_W-1:0] ext_byte(input logic [BYTE_W-1:0] prev);
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        if (prev == CHR_CR && b == CHR_LF) b = 8'h20;
        return b;
    endfunction

    function automatic void push_crlf();
        body_bytes.push_back(CHR_CR);
        body_bytes.push_back(CHR_LF);
    endfunction

    // Size line: optional leading zeros, hex digits, optional extension, CR LF.
    // budget = bytes allowed before the CR LF.
    function automatic void add_size_line(input logic [SIZE_BITS-1:0] size,
                                          input bit empty_ok, input int budget);
        logic [3:0]        digs[$];
        logic [SIZE_BITS-1:0] v;
        logic [BYTE_W-1:0] prev;
        int                pad, room, ext_len;
        v = size;
        do begin
            digs.push_front(v[3:0]);
            v = v >> 4;
        end while (v != '0);
        // zero chunk may also be written with no digits at all
        if (size == '0 && empty_ok && $urandom_range(0, 1) == 0) digs.delete();
        room = budget - digs.size();
        pad  = 0;
        if (room > 0 && $urandom_range(0, 3) == 0) pad = $urandom_range(0, room > 20 ? 20 : room);
        repeat (pad) body_bytes.push_back("0");
        foreach (digs[i]) body_bytes.push_back(hex_char(digs[i]));
        room -= pad;
        ext_len = 0;
        if (room > 0 && room <= 40 && $urandom_range(0, 4) == 0)
            ext_len = room;                                 // line fills the whole budget
        else if (room > 0 && $urandom_range(0, 2) == 0)
            ext_len = $urandom_range(1, room > 12 ? 12 : room);
        if (ext_len > 0) begin
            prev = non_hex_byte();
            body_bytes.push_back(prev);
            repeat (ext_len - 1) begin
                prev = ext_byte(prev);
                body_bytes.push_back(prev);
            end
        end
        push_crlf();
    endfunction

    // Well-formed message: 0..3 data chunks, then the zero chunk and final CR LF.
    function automatic void add_message(input int budget);
        int n_chunks, size;
        n_chunks = $urandom_range(0, 3);
        repeat (n_chunks) begin
            if (budget < 2)
                size = $urandom_range(1, 15);
            else if ($urandom_range(0, 7) == 0)
                size = $urandom_range(13, 60);
            else
                size = $urandom_range(1, 12);
            add_size_line(SIZE_BITS'(size), 1'b0, budget);
            repeat (size) body_bytes.push_back(8'($urandom_range(0, 255)));
            push_crlf();
        end
        add_size_line('0, 1'b1, budget);
        push_crlf();
    endfunction

    // Sends everything queued; valid stays up between back-to-back items.
    task automatic push_out();
        int                gap;
        logic [BYTE_W-1:0] b;
        while (body_bytes.size() != 0) begin
            b   = body_bytes.pop_front();
            gap = pick_gap(tx_quiet);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid     <= 1'b1;
            s_data_byte <= b;
            do @(posedge aclk); while (!s_ready);
        end
    endtask

    // Wait until every predicted item has come out, then let the pipe settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (6) @(posedge aclk);
    endtask

    // One APB transfer to max_line_len; it returns only after psel has been low at a clock
    // edge, so back-to-back calls never lower and raise psel in the same step.
    task automatic apb_xfer(input bit wr, input logic [LINE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_MAX_LINE_LEN, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: random stalls per item.
    initial begin : result_sink
        int gap;
        forever begin
            gap = pick_gap(rx_quiet);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        int                budget, size;
        logic [ERR_W-1:0]  err_kind;
        logic [BYTE_W-1:0] b;

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_xfer(1'b0, '0);                 // reset value of max_line_len
        cur_limit = MAX_LINE_LEN_RST;

        // Directed: empty size line as last chunk, payload bytes 00/FF,
        // lone CR inside a size line followed by an extension.
        push_crlf();
        push_crlf();
        body_bytes.push_back("2");
        push_crlf();
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'hFF);
        push_crlf();
        body_bytes.push_back("0");
        push_crlf();
        push_crlf();
        body_bytes.push_back("1");
        body_bytes.push_back(CHR_CR);
        body_bytes.push_back("x");
        push_crlf();
        body_bytes.push_back(8'h5A);
        push_crlf();
        push_crlf();
        push_crlf();
        push_out();
        drain();

        // Random messages under a sequence of line limits, extremes included.
        for (int p = 0; p < 7; p++) begin
            case (p)
                0, 4:    cur_limit = 16'd3;
                1, 5:    cur_limit = 16'hFFFF;
                2:       cur_limit = LINE_W'($urandom_range(4, 40));
                3:       cur_limit = LINE_W'($urandom_range(41, 65534));
                default: cur_limit = LINE_W'($urandom_range(3, 200));
            endcase
            apb_xfer(1'b1, cur_limit);
            apb_xfer(1'b0, '0);
            budget = (cur_limit > 62) ? 60 : cur_limit - 2;
            while (body_bytes.size() < 220) add_message(budget);
            push_out();
            drain();
        end

        // Errors stick until reset, so exactly one error closes the run.
        cur_limit = LINE_W'($urandom_range(20, 40));
        apb_xfer(1'b1, cur_limit);
        budget = cur_limit - 2;
        add_message(budget);
        err_kind = ERR_W'($urandom_range(ERR_CRLF, ERR_OVF));
        case (err_kind)
            ERR_CRLF: begin
                // bad end after the zero chunk's line or after a data chunk
                if ($urandom_range(0, 1) == 0) begin
                    add_size_line('0, 1'b1, budget);
                end else begin
                    size = $urandom_range(1, 8);
                    add_size_line(SIZE_BITS'(size), 1'b0, budget);
                    repeat (size) body_bytes.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 1) == 0) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CHR_CR) b = 8'h00;
                    body_bytes.push_back(b);
                end else begin
                    body_bytes.push_back(CHR_CR);
                    b = 8'($urandom_range(0, 255));
                    if (b == CHR_LF) b = 8'h00;
                    body_bytes.push_back(b);
                end
            end
            ERR_LINE: begin
                // size line one byte longer than the limit
                body_bytes.push_back("1");
                b = ";";
                body_bytes.push_back(b);
                repeat (cur_limit - 1) begin
                    b = ext_byte(b);
                    body_bytes.push_back(b);
                end
            end
            default: begin
                // 17 significant hex digits overflow the size
                body_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
                repeat (16) body_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            end
        endcase
        // swallowed silently after the error
        repeat (6) body_bytes.push_back(8'($urandom_range(0, 255)));
        push_out();
        drain();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
